@@ rtl/three_axis_rate_pid_core_defines.svh @@
// ----------------------------------------------------------------------------
// Three-axis rate PID core: shared assertion macros
// Concurrent assertion wrappers used by the core and its lanes.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_RATE_PID_CORE_DEFINES_SVH
`define THREE_AXIS_RATE_PID_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rate pid core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define TRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rate pid core: next-cycle check failed");

`endif

@@ rtl/trp_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-axis rate PID package
// Fixed-point widths, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trp_pkg;

	// Format choices
	localparam int GAIN_FRAC_BITS = 10;
	localparam int RATE_WIDTH     = 16;

	// Fixed field widths
	localparam int AXES      = 3;
	localparam int GAIN_W    = 16;
	localparam int LIM_W     = 15;
	localparam int DRIVE_W   = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int TUNE_W    = 3 * GAIN_W + LIM_W;

	// Derived arithmetic widths
	localparam int ERR_W  = RATE_WIDTH + 1;
	localparam int DERR_W = RATE_WIDTH + 2;
	localparam int GSX_W  = GAIN_W + 1;
	localparam int PE_W   = ERR_W + GSX_W;
	localparam int DE_W   = DERR_W + GSX_W;
	localparam int INT_W  = LIM_W + GAIN_FRAC_BITS + 1;
	localparam int IACC_W = ((INT_W > PE_W) ? INT_W : PE_W) + 1;
	localparam int PD_W   = ((DE_W > PE_W) ? DE_W : PE_W) + 1;
	localparam int ACC_W  = ((PD_W > INT_W) ? PD_W : INT_W) + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd2;

	// One axis tuning word, bit 63 dropped
	typedef struct packed {
		logic [LIM_W-1:0]  lim;
		logic [GAIN_W-1:0] d;
		logic [GAIN_W-1:0] i;
		logic [GAIN_W-1:0] p;
	} trp_tuning_t;

	// Stage load strobes shared by all lanes
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} trp_stage_en_t;

endpackage

`default_nettype wire

@@ rtl/trp_axis_lane.sv @@
// ----------------------------------------------------------------------------
// Rate PID axis lane
// Error, gain products, clamped integrator and clamped drive for one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "three_axis_rate_pid_core_defines.svh"

module trp_axis_lane (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire trp_pkg::trp_stage_en_t               en,
	input  wire logic                                 restart,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] rate,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] target,
	input  wire trp_pkg::trp_tuning_t                 tuning,
	output logic signed [trp_pkg::DRIVE_W-1:0]        drive
);

	logic signed [trp_pkg::ERR_W-1:0]  err;
	logic signed [trp_pkg::ERR_W-1:0]  prev_eff;
	logic signed [trp_pkg::DERR_W-1:0] derr;
	logic signed [trp_pkg::ERR_W-1:0]  prev_q;

	logic signed [trp_pkg::ERR_W-1:0]  err_s1;
	logic signed [trp_pkg::DERR_W-1:0] derr_s1;
	logic                              restart_s1;

	logic signed [trp_pkg::GSX_W-1:0]  p_sx;
	logic signed [trp_pkg::GSX_W-1:0]  i_sx;
	logic signed [trp_pkg::GSX_W-1:0]  d_sx;
	logic signed [trp_pkg::PE_W-1:0]   pe_s2;
	logic signed [trp_pkg::PE_W-1:0]   ie_s2;
	logic signed [trp_pkg::DE_W-1:0]   de_s2;
	logic                              restart_s2;

	logic signed [trp_pkg::INT_W-1:0]  integ_q;
	logic signed [trp_pkg::INT_W-1:0]  integ_base;
	logic signed [trp_pkg::IACC_W-1:0] lim_fx;
	logic signed [trp_pkg::IACC_W-1:0] isum;
	logic signed [trp_pkg::IACC_W-1:0] iclamp;
	logic signed [trp_pkg::PD_W-1:0]   pd_s3;
	logic signed [trp_pkg::INT_W-1:0]  ig_s3;

	logic signed [trp_pkg::ACC_W-1:0]  acc;
	logic signed [trp_pkg::ACC_W-1:0]  acc_sh;
	logic signed [trp_pkg::ACC_W-1:0]  lim_x;
	logic signed [trp_pkg::ACC_W-1:0]  dclamp;

	// Error and error delta at acceptance; restart drops the previous error
	always_comb begin
		err      = trp_pkg::ERR_W'(rate) - trp_pkg::ERR_W'(target);
		prev_eff = restart ? '0 : prev_q;
		derr     = trp_pkg::DERR_W'(err) - trp_pkg::DERR_W'(prev_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (en.ld_s1) begin
			prev_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			err_s1     <= err;
			derr_s1    <= derr;
			restart_s1 <= restart;
		end
	end

	// Stage 2: the three gain products
	assign p_sx = $signed({1'b0, tuning.p});
	assign i_sx = $signed({1'b0, tuning.i});
	assign d_sx = $signed({1'b0, tuning.d});

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			pe_s2      <= trp_pkg::PE_W'(p_sx) * trp_pkg::PE_W'(err_s1);
			ie_s2      <= trp_pkg::PE_W'(i_sx) * trp_pkg::PE_W'(err_s1);
			de_s2      <= trp_pkg::DE_W'(d_sx) * trp_pkg::DE_W'(derr_s1);
			restart_s2 <= restart_s1;
		end
	end

	// Stage 3: integrator add and clamp, one item per cycle while stage 3 advances
	always_comb begin
		integ_base = restart_s2 ? '0 : integ_q;
		lim_fx     = trp_pkg::IACC_W'({tuning.lim, {trp_pkg::GAIN_FRAC_BITS{1'b0}}});
		isum       = trp_pkg::IACC_W'(integ_base) + trp_pkg::IACC_W'(ie_s2);
		if (isum > lim_fx) begin
			iclamp = lim_fx;
		end else if (isum < -lim_fx) begin
			iclamp = -lim_fx;
		end else begin
			iclamp = isum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (en.ld_s3) begin
			integ_q <= trp_pkg::INT_W'(iclamp);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			pd_s3 <= trp_pkg::PD_W'(pe_s2) + trp_pkg::PD_W'(de_s2);
			ig_s3 <= trp_pkg::INT_W'(iclamp);
		end
	end

	// Final sum, floor shift to whole units, clamp to the limit
	always_comb begin
		acc    = trp_pkg::ACC_W'(pd_s3) + trp_pkg::ACC_W'(ig_s3);
		acc_sh = acc >>> trp_pkg::GAIN_FRAC_BITS;
		lim_x  = trp_pkg::ACC_W'(tuning.lim);
		if (acc_sh > lim_x) begin
			dclamp = lim_x;
		end else if (acc_sh < -lim_x) begin
			dclamp = -lim_x;
		end else begin
			dclamp = acc_sh;
		end
	end

	assign drive = trp_pkg::DRIVE_W'(dclamp);

	// A zero limit pins the integrator at zero
	`TRP_ASSERT_NEXT(a_zero_lim_integ, clk, arst_n, en.ld_s3 && (tuning.lim == '0), integ_q == '0)

endmodule

`default_nettype wire

@@ rtl/trp_merge.sv @@
// ----------------------------------------------------------------------------
// Rate PID result merge
// Joins the three lane drives into one registered result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trp_merge (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          valid_s3,
	input  wire logic signed [trp_pkg::AXES-1:0][trp_pkg::DRIVE_W-1:0] lane_drive,
	input  wire logic                                          out_ready,
	output logic                                               out_valid,
	output logic                                               out_free,
	output logic signed [trp_pkg::DRIVE_W-1:0]                 roll_drive,
	output logic signed [trp_pkg::DRIVE_W-1:0]                 pitch_drive,
	output logic signed [trp_pkg::DRIVE_W-1:0]                 yaw_drive
);

	logic out_valid_q;
	logic load;

	// Output slot is free when empty or being taken this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign load      = valid_s3 && out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			roll_drive  <= lane_drive[0];
			pitch_drive <= lane_drive[1];
			yaw_drive   <= lane_drive[2];
		end
	end

endmodule

`default_nettype wire

@@ rtl/three_axis_rate_pid_core.sv @@
// ----------------------------------------------------------------------------
// Three-axis rate PID core
// Roll, pitch and yaw rate PID lanes with integrator clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction (in_valid/in_ready): restart flag plus measured and
//   target rates for the three axes. Output transaction (out_valid/out_ready):
//   one drive per axis, clamped to that axis's limit.
//   Tuning words are written through cfg_we/cfg_index/cfg_data while the core
//   is idle; index 0 roll, 1 pitch, 2 yaw, other indexes are ignored.
//   Three identical lanes run in lockstep, one per axis; a merge register
//   joins their drives into one result.
//   The result passes through three lane stages, then the merge register,
//   before out_valid rises for an accepted input transaction.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the integrator add-and-clamp loop in stage 3 updates in each cycle it loads.
//   Reset clears the tuning words, integrators, previous errors and all
//   pipeline valids; in_ready is high right after reset.
//   When the receiver stalls, the result holds and the pipeline keeps
//   accepting until its three stages are full, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "three_axis_rate_pid_core_defines.svh"

module three_axis_rate_pid_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [trp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [trp_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  restart,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] roll_rate,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] pitch_rate,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] yaw_rate,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] roll_target,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] pitch_target,
	input  wire logic signed [trp_pkg::RATE_WIDTH-1:0] yaw_target,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [trp_pkg::DRIVE_W-1:0]         roll_drive,
	output logic signed [trp_pkg::DRIVE_W-1:0]         pitch_drive,
	output logic signed [trp_pkg::DRIVE_W-1:0]         yaw_drive
);

	trp_pkg::trp_tuning_t    tuning_q [trp_pkg::AXES];
	trp_pkg::trp_stage_en_t  en;

	logic signed [trp_pkg::RATE_WIDTH-1:0]            rate_a   [trp_pkg::AXES];
	logic signed [trp_pkg::RATE_WIDTH-1:0]            target_a [trp_pkg::AXES];
	logic signed [trp_pkg::AXES-1:0][trp_pkg::DRIVE_W-1:0] lane_drive;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic adv1;
	logic adv2;
	logic adv3;
	logic out_free;

	// Tuning register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < trp_pkg::AXES; a++) begin
				tuning_q[a] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				trp_pkg::REG_ROLL:  tuning_q[0] <= trp_pkg::trp_tuning_t'(cfg_data[trp_pkg::TUNE_W-1:0]);
				trp_pkg::REG_PITCH: tuning_q[1] <= trp_pkg::trp_tuning_t'(cfg_data[trp_pkg::TUNE_W-1:0]);
				trp_pkg::REG_YAW:   tuning_q[2] <= trp_pkg::trp_tuning_t'(cfg_data[trp_pkg::TUNE_W-1:0]);
				default: ;
			endcase
		end
	end

	// Pipeline advance: a stage moves when empty or when the next one moves
	assign adv3     = !valid_s3 || out_free;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	assign en.ld_s1 = in_valid && in_ready;
	assign en.ld_s2 = valid_s1 && adv2;
	assign en.ld_s3 = valid_s2 && adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Axis lanes
	assign rate_a[0]   = roll_rate;
	assign rate_a[1]   = pitch_rate;
	assign rate_a[2]   = yaw_rate;
	assign target_a[0] = roll_target;
	assign target_a[1] = pitch_target;
	assign target_a[2] = yaw_target;

	for (genvar a = 0; a < trp_pkg::AXES; a++) begin : g_lane
		trp_axis_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.restart (restart),
			.rate    (rate_a[a]),
			.target  (target_a[a]),
			.tuning  (tuning_q[a]),
			.drive   (lane_drive[a])
		);
	end

	// Result merge and output register
	trp_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.lane_drive  (lane_drive),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_free    (out_free),
		.roll_drive  (roll_drive),
		.pitch_drive (pitch_drive),
		.yaw_drive   (yaw_drive)
	);

	// Pipeline control checks
	`TRP_ASSERT_NEXT(a_s3_holds, clk, arst_n, valid_s3 && !out_free, valid_s3)
	`TRP_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`TRP_ASSERT_IMPL(a_empty_s1_ready, clk, arst_n, !valid_s1, in_ready)

endmodule

`default_nettype wire
